@@ rtl/gsu_pkg.sv @@
// ----------------------------------------------------------------------------
// gsu_pkg : shared types and helpers for the septet unpacker
// Entry format of the result queue, push group and the 03.38 to ASCII map.
// ----------------------------------------------------------------------------
package gsu_pkg;

  localparam int unsigned SEPTET_W = 7;
  localparam int unsigned STORE_W  = 14;
  localparam int unsigned HELD_W   = 4;
  localparam int unsigned COUNT_W  = 8;
  localparam int unsigned FILL_W   = 3;

  localparam logic [SEPTET_W-1:0] QMARK      = 7'h3F;
  localparam logic [SEPTET_W-1:0] AT_SIGN    = 7'h40;
  localparam logic [SEPTET_W-1:0] DOLLAR     = 7'h24;
  localparam logic [SEPTET_W-1:0] UNDERSCORE = 7'h5F;

  // one result: septet plus end-of-message flag
  typedef struct packed {
    logic                last;
    logic [SEPTET_W-1:0] value;
  } res_entry_t;

  // up to two results produced by one byte; second valid implies first
  typedef struct packed {
    logic       v0;
    logic       v1;
    res_entry_t e0;
    res_entry_t e1;
  } res_push_t;

  function automatic logic [SEPTET_W-1:0] gsm_to_ascii(input logic [SEPTET_W-1:0] c);
    logic [SEPTET_W-1:0] r;
    r = QMARK;
    if (c == 7'h24 || c == 7'h40) begin
      r = QMARK;
    end else if ((c >= 7'h20 && c <= 7'h5A) || (c >= 7'h61 && c <= 7'h7A) ||
                 c == 7'h0A || c == 7'h0D) begin
      r = c;
    end else if (c == 7'h00) begin
      r = AT_SIGN;
    end else if (c == 7'h02) begin
      r = DOLLAR;
    end else if (c == 7'h11) begin
      r = UNDERSCORE;
    end
    return r;
  endfunction

endpackage

@@ rtl/gsu_core.sv @@
// ----------------------------------------------------------------------------
// gsu_core : input register, bit buffer and septet extraction
// Holds one byte beat, starts or extends the bit buffer with it and peels off up to two
// septets in one pass when the result queue has room for two.
// ----------------------------------------------------------------------------
module gsu_core (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [7:0]               in_byte,
  input  logic                     in_start,
  input  logic [gsu_pkg::FILL_W-1:0]  in_fill,
  input  logic [gsu_pkg::COUNT_W-1:0] in_count,
  input  logic                     map_en,
  input  logic                     space_ok,
  output gsu_pkg::res_push_t       push
);
  import gsu_pkg::*;

  logic                hold_v_r;
  logic [7:0]          byte_r;
  logic                start_r;
  logic [FILL_W-1:0]   fill_r;
  logic [COUNT_W-1:0]  count_r;

  logic [STORE_W-1:0]  store_r, store_nxt;
  logic [HELD_W-1:0]   held_r, held_nxt;
  logic [COUNT_W-1:0]  left_r, left_nxt;

  logic                consume;
  logic                active;
  logic [STORE_W-1:0]  st0, st1;
  logic [HELD_W-1:0]   bh0, bh1;
  logic [COUNT_W-1:0]  cl0, cl1;
  logic                e0, e1;
  logic [SEPTET_W-1:0] c0, c1;

  assign consume  = hold_v_r && space_ok;
  assign in_ready = !hold_v_r || consume;

  always_comb begin
    active = 1'b1;
    st0    = store_r;
    bh0    = held_r;
    cl0    = left_r;
    if (start_r) begin
      cl0 = count_r;
      st0 = {6'd0, byte_r} >> fill_r;
      bh0 = HELD_W'(8) - {1'b0, fill_r};
    end else if (left_r == '0) begin
      // message already done: drop the byte, keep state
      active = 1'b0;
    end else begin
      st0 = store_r | ({6'd0, byte_r} << held_r[2:0]);
      bh0 = held_r + HELD_W'(8);
    end

    e0  = active && (cl0 != '0) && (bh0 >= HELD_W'(7));
    c0  = st0[SEPTET_W-1:0];
    st1 = e0 ? (st0 >> SEPTET_W) : st0;
    bh1 = e0 ? (bh0 - HELD_W'(7)) : bh0;
    cl1 = e0 ? (cl0 - COUNT_W'(1)) : cl0;

    e1 = e0 && (cl1 != '0) && (bh1 >= HELD_W'(7));
    c1 = st1[SEPTET_W-1:0];
    store_nxt = e1 ? (st1 >> SEPTET_W) : st1;
    held_nxt  = e1 ? (bh1 - HELD_W'(7)) : bh1;
    left_nxt  = e1 ? (cl1 - COUNT_W'(1)) : cl1;

    push.v0       = consume && e0;
    push.v1       = consume && e1;
    push.e0.value = map_en ? gsm_to_ascii(c0) : c0;
    push.e0.last  = (cl1 == '0);
    push.e1.value = map_en ? gsm_to_ascii(c1) : c1;
    push.e1.last  = (left_nxt == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r <= 1'b0;
      store_r  <= '0;
      held_r   <= '0;
      left_r   <= '0;
    end else begin
      if (in_ready) begin
        hold_v_r <= in_valid;
      end
      if (consume) begin
        store_r <= store_nxt;
        held_r  <= held_nxt;
        left_r  <= left_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_r  <= in_byte;
      start_r <= in_start;
      fill_r  <= in_fill;
      count_r <= in_count;
    end
  end

endmodule

@@ rtl/gsu_out_queue.sv @@
// ----------------------------------------------------------------------------
// gsu_out_queue : four-entry result queue
// Takes up to two results per cycle, hands out one per beat.
// ----------------------------------------------------------------------------
module gsu_out_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  gsu_pkg::res_push_t    push,
  output logic                  space_ok,
  output logic                  out_valid,
  input  logic                  out_ready,
  output gsu_pkg::res_entry_t   out_entry
);
  import gsu_pkg::*;

  localparam int unsigned DEPTH = 4;

  res_entry_t  mem_r [DEPTH];
  logic [1:0]  head_r, tail_r;
  logic [2:0]  cnt_r, cnt_nxt;
  logic        pop;
  logic [1:0]  push_n;

  assign out_valid = (cnt_r != '0);
  assign out_entry = mem_r[head_r];
  assign pop       = out_valid && out_ready;
  // room for two more regardless of this cycle's pop
  assign space_ok  = (cnt_r <= 3'd2);
  assign push_n    = {1'b0, push.v0} + {1'b0, push.v1};
  assign cnt_nxt   = cnt_r + {1'b0, push_n} - {2'b00, pop};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      cnt_r  <= '0;
    end else begin
      cnt_r  <= cnt_nxt;
      tail_r <= tail_r + push_n;
      if (pop) begin
        head_r <= head_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push.v0) begin
      mem_r[tail_r] <= push.e0;
    end
    if (push.v1) begin
      mem_r[tail_r + 2'd1] <= push.e1;
    end
  end

endmodule

@@ rtl/gsm_septet_unpacker_unit.sv @@
// ----------------------------------------------------------------------------
// gsm_septet_unpacker_unit : packed SMS user data to 7-bit characters
// Unpacks GSM 03.38 septets from a byte stream, optionally mapped to ASCII.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one packed user-data byte per beat. in_tuser high marks the
//           first byte of a message; fill bits and septet count are taken
//           from that beat only.
//   out_* : one character per beat, out_tlast on the final septet.
//   cfg_* : map_to_ascii bit, always ready; write only while the block idles.
// Timing: an accepted byte is captured in the input register, its characters
//   are written to the result queue together and leave it one per beat.
// Throughput: one byte per cycle while each byte yields at most one
//   character and out_tready stays high; a byte that yields two sends both
//   through the single-beat out port, so a long message is paced by that
//   port. The four-entry result queue gates intake: a byte is processed only
//   when two slots are free.
// Reset: clears the bit buffer, held-bit and septet counters, the queue and
//   the mode bit (raw septets).
// Stall: with out_tready low the queue fills, the held byte waits and
//   in_tready drops; nothing is lost.
// ----------------------------------------------------------------------------
module gsm_septet_unpacker_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // data_byte[7:0], fill_bits[10:8], char_count[18:11]
  input  logic [0:0]  in_tuser,   // start_req[0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // char_value[6:0]
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_data    // map_to_ascii[0]
);
  import gsu_pkg::*;

  logic       map_r;
  logic       space_ok;
  res_push_t  push;
  res_entry_t head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      map_r <= cfg_data[0];
    end
  end

  gsu_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_byte  (in_tdata[7:0]),
    .in_start (in_tuser[0]),
    .in_fill  (in_tdata[10:8]),
    .in_count (in_tdata[18:11]),
    .map_en   (map_r),
    .space_ok (space_ok),
    .push     (push)
  );

  gsu_out_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .space_ok  (space_ok),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_entry (head)
  );

  assign out_tdata = {1'b0, head.value};
  assign out_tlast = head.last;

endmodule
